>>> rtl/alt_pkg.sv
// Shared widths, codes and controller/datapath interface types for the arc length table.
`default_nettype none

package alt_pkg;

	localparam int MODE_W = 2;
	localparam int IDX_W = 11;
	localparam int VAL_W = 17;
	localparam int STEP_W = 6;
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 17;

	// fraction bits of the bisection bounds; enough for every midpoint of the step limit
	localparam int UFRAC = 50;

	localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FWD = 2'd1;
	localparam logic [MODE_W-1:0] MODE_INV = 2'd2;

	localparam logic [CFG_IW-1:0] CFG_COUNT = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_SPACING = 2'd1;

	localparam logic [IDX_W-1:0] COUNT_RST = 11'd1024;
	localparam logic [VAL_W-1:0] SPACING_RST = 17'd64;
	localparam logic [VAL_W-1:0] VAL_MAX = 17'h1FFFF;
	localparam logic [STEP_W-1:0] MAX_STEPS = 6'd50;

	typedef struct packed {
		logic load_wr;
		logic fwd_start;
		logic inv_start;
		logic fwd_mul;
		logic fwd_addr;
		logic fwd_prod;
		logic fwd_sum;
		logic inv_addr;
		logic inv_cmp;
		logic inv_res;
		logic out_load;
	} alt_cmd_t;

	typedef struct packed {
		logic inv_stop;
	} alt_stat_t;

endpackage

`default_nettype wire

>>> rtl/arc_length_table_lookup.sv
// Top level: arc length table with forward interpolation and inverse bisection queries.
//
//  channel | direction | handshake             | beat contents
//  --------+-----------+-----------------------+----------------------------------------------
//  in      | to block  | in_valid / in_stall   | mode, entry_index, entry_value, query_value
//  out     | from block| out_valid / out_stall | result_value, result_index, step_count
//  cfg     | to block  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Load beats are written to the table in the cycle they are taken; the next beat may follow.
// Forward query: multiply, table read, multiply, add, then the result is registered to the output.
// Inverse query: bisection steps of table read then compare, 1 to 50 steps, then the result step.
// One query is in flight at a time; a finished result waits in the output register and the
// block takes further beats meanwhile. Reset is asynchronous and clears control and config;
// table contents are undefined until loaded, and there is no clearing pass.
`default_nettype none

module arc_length_table_lookup #(
	parameter int MAX_INTERVALS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [alt_pkg::MODE_W-1:0]  mode,
	input  logic [alt_pkg::IDX_W-1:0]   entry_index,
	input  logic [alt_pkg::VAL_W-1:0]   entry_value,
	input  logic [alt_pkg::VAL_W-1:0]   query_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [alt_pkg::VAL_W-1:0]   result_value,
	output logic [alt_pkg::IDX_W-1:0]   result_index,
	output logic [alt_pkg::STEP_W-1:0]  step_count,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [alt_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [alt_pkg::CFG_DW-1:0]  cfg_data
);
	import alt_pkg::*;

	alt_cmd_t  cmd;
	alt_stat_t stat;

	assign cfg_ready = 1'b1;

	alt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_mode   (mode),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	alt_dpath #(
		.MAX_INTERVALS (MAX_INTERVALS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.entry_index  (entry_index),
		.entry_value  (entry_value),
		.query_value  (query_value),
		.cmd          (cmd),
		.stat         (stat),
		.result_value (result_value),
		.result_index (result_index),
		.step_count   (step_count)
	);

endmodule

`default_nettype wire

>>> rtl/alt_ctrl.sv
// Controller state machine: sequences load, forward and bisection items.
`default_nettype none

module alt_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [alt_pkg::MODE_W-1:0]  in_mode,
	output logic                        in_stall,
	output logic                        out_valid,
	input  logic                        out_stall,
	input  alt_pkg::alt_stat_t          stat,
	output alt_pkg::alt_cmd_t           cmd
);
	import alt_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_F_MUL  = 4'd1;
	localparam logic [3:0] ST_F_ADDR = 4'd2;
	localparam logic [3:0] ST_F_PROD = 4'd3;
	localparam logic [3:0] ST_F_SUM  = 4'd4;
	localparam logic [3:0] ST_I_ADDR = 4'd5;
	localparam logic [3:0] ST_I_CMP  = 4'd6;
	localparam logic [3:0] ST_I_RES  = 4'd7;
	localparam logic [3:0] ST_DONE   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nx;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.load_wr = accept && (in_mode == MODE_LOAD);
		cmd.fwd_start = accept && (in_mode == MODE_FWD);
		cmd.inv_start = accept && (in_mode == MODE_INV);
		cmd.fwd_mul = (state_q == ST_F_MUL);
		cmd.fwd_addr = (state_q == ST_F_ADDR);
		cmd.fwd_prod = (state_q == ST_F_PROD);
		cmd.fwd_sum = (state_q == ST_F_SUM);
		cmd.inv_addr = (state_q == ST_I_ADDR);
		cmd.inv_cmp = (state_q == ST_I_CMP);
		cmd.inv_res = (state_q == ST_I_RES);
		cmd.out_load = (state_q == ST_DONE) && out_free;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.fwd_start)
					state_nx = ST_F_MUL;
				else if (cmd.inv_start)
					state_nx = ST_I_ADDR;
			end
			ST_F_MUL:  state_nx = ST_F_ADDR;
			ST_F_ADDR: state_nx = ST_F_PROD;
			ST_F_PROD: state_nx = ST_F_SUM;
			ST_F_SUM:  state_nx = ST_DONE;
			ST_I_ADDR: state_nx = ST_I_CMP;
			ST_I_CMP:  state_nx = stat.inv_stop ? ST_I_RES : ST_I_ADDR;
			ST_I_RES:  state_nx = ST_DONE;
			ST_DONE: begin
				if (out_free)
					state_nx = ST_IDLE;
			end
			default:   state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

>>> rtl/alt_dpath.sv
// Datapath: config registers, arc table memory, forward interpolation and bisection arithmetic.
`default_nettype none

module alt_dpath #(
	parameter int MAX_INTERVALS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [alt_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [alt_pkg::CFG_DW-1:0]  cfg_data,
	input  logic [alt_pkg::IDX_W-1:0]   entry_index,
	input  logic [alt_pkg::VAL_W-1:0]   entry_value,
	input  logic [alt_pkg::VAL_W-1:0]   query_value,
	input  alt_pkg::alt_cmd_t           cmd,
	output alt_pkg::alt_stat_t          stat,
	output logic [alt_pkg::VAL_W-1:0]   result_value,
	output logic [alt_pkg::IDX_W-1:0]   result_index,
	output logic [alt_pkg::STEP_W-1:0]  step_count
);
	import alt_pkg::*;

	localparam int CW = $clog2(MAX_INTERVALS + 1);
	localparam int SCW = VAL_W + CW;
	localparam int DW = VAL_W + 1;
	localparam int PW = SCW + 1 + DW;
	localparam int UW = CW + UFRAC;
	localparam logic signed [PW-1:0] RND_HALF = PW'(32'sd32768);
	localparam logic signed [PW-1:0] SAT_HI = PW'(32'sd131071);

	// configuration
	logic [IDX_W-1:0] count_q;
	logic [VAL_W-1:0] spacing_q;
	logic [CW-1:0]    cnt_eff;
	logic [CW-1:0]    cnt_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RST;
			spacing_q <= SPACING_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COUNT:   count_q <= cfg_data[IDX_W-1:0];
				CFG_SPACING: spacing_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	always_comb begin
		if (count_q == '0)
			cnt_eff = CW'(1);
		else if (32'(count_q) > MAX_INTERVALS)
			cnt_eff = CW'(MAX_INTERVALS);
		else
			cnt_eff = CW'(count_q);
	end
	assign cnt_m1 = cnt_eff - CW'(1);

	// arc table, two registered read ports
	logic [VAL_W-1:0] arc_mem [0:MAX_INTERVALS];
	logic [CW-1:0]    addr_a;
	logic [CW-1:0]    addr_b;
	logic [VAL_W-1:0] rd_a_q;
	logic [VAL_W-1:0] rd_b_q;
	logic             load_ok;

	assign load_ok = (32'(entry_index) <= MAX_INTERVALS);

	always_ff @(posedge clk) begin
		if (cmd.load_wr && load_ok)
			arc_mem[CW'(entry_index)] <= entry_value;
		rd_a_q <= arc_mem[addr_a];
		rd_b_q <= arc_mem[addr_b];
	end

	// shared item registers
	logic [VAL_W-1:0]  query_q;
	logic [CW-1:0]     idx_q;
	logic [VAL_W-1:0]  res_val_q;
	logic [IDX_W-1:0]  res_idx_q;
	logic [STEP_W-1:0] res_steps_q;

	// forward path
	logic [SCW-1:0]         scaled_q;
	logic [SCW-16-1:0]      fidx_raw;
	logic [CW-1:0]          fidx;
	logic [CW-1:0]          fidx_nx;
	logic [SCW-1:0]         frac;
	logic [SCW-1:0]         k_q;
	logic signed [DW-1:0]   diff;
	logic signed [PW-1:0]   prod_q;
	logic [VAL_W-1:0]       a_q;
	logic signed [PW-1:0]   rnd;
	logic signed [PW-1:0]   fsum;

	assign fidx_raw = scaled_q[SCW-1:16];
	assign fidx = (fidx_raw > {1'b0, cnt_m1}) ? cnt_m1 : fidx_raw[CW-1:0];
	assign fidx_nx = fidx + CW'(1);
	// fraction may exceed one when the index was clamped at the top
	assign frac = scaled_q - SCW'({fidx, 16'h0000});
	assign diff = $signed({1'b0, rd_b_q}) - $signed({1'b0, rd_a_q});
	assign rnd = (prod_q + RND_HALF) >>> 16;
	assign fsum = rnd + PW'($signed({1'b0, a_q}));

	// bisection path; bounds are held already scaled by the count
	logic [UW-1:0]      lo_q;
	logic [UW-1:0]      hi_q;
	logic [UW-1:0]      mid_q;
	logic [UW:0]        bsum;
	logic [UW-1:0]      mid;
	logic [CW-1:0]      iidx;
	logic [CW-1:0]      ipred;
	logic [STEP_W-1:0]  steps_q;
	logic [STEP_W-1:0]  steps_nx;
	logic [VAL_W-1:0]   qerr;
	logic [VAL_W-1:0]   gap;
	logic [CW+VAL_W-1:0] ivprod;

	assign bsum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = bsum[UW:1];
	assign iidx = mid[UW-1:UFRAC];
	assign ipred = (iidx == '0) ? iidx : iidx - CW'(1);
	assign steps_nx = steps_q + STEP_W'(1);
	assign qerr = (rd_a_q >= query_q) ? rd_a_q - query_q : query_q - rd_a_q;
	assign gap = (rd_a_q >= rd_b_q) ? rd_a_q - rd_b_q : rd_b_q - rd_a_q;
	assign stat.inv_stop = (qerr <= gap) || (steps_nx >= MAX_STEPS);
	assign ivprod = (CW + VAL_W)'(idx_q) * (CW + VAL_W)'(spacing_q);

	assign addr_a = cmd.fwd_addr ? fidx : iidx;
	assign addr_b = cmd.fwd_addr ? fidx_nx : ipred;

	always_ff @(posedge clk) begin
		if (cmd.fwd_start || cmd.inv_start)
			query_q <= query_value;
		if (cmd.inv_start) begin
			lo_q <= '0;
			hi_q <= {cnt_eff, {UFRAC{1'b0}}};
			steps_q <= '0;
		end
		if (cmd.fwd_mul)
			scaled_q <= SCW'(query_q) * SCW'(cnt_eff);
		if (cmd.fwd_addr) begin
			idx_q <= fidx;
			k_q <= frac;
		end
		if (cmd.fwd_prod) begin
			prod_q <= $signed({1'b0, k_q}) * diff;
			a_q <= rd_a_q;
		end
		if (cmd.fwd_sum) begin
			if (fsum < 0)
				res_val_q <= '0;
			else if (fsum > SAT_HI)
				res_val_q <= VAL_MAX;
			else
				res_val_q <= fsum[VAL_W-1:0];
			res_idx_q <= IDX_W'(idx_q);
			res_steps_q <= '0;
		end
		if (cmd.inv_addr) begin
			mid_q <= mid;
			idx_q <= iidx;
		end
		if (cmd.inv_cmp) begin
			if (rd_a_q > query_q)
				hi_q <= mid_q;
			else
				lo_q <= mid_q;
			steps_q <= steps_nx;
		end
		if (cmd.inv_res) begin
			res_val_q <= (ivprod > (CW + VAL_W)'(VAL_MAX)) ? VAL_MAX : ivprod[VAL_W-1:0];
			res_idx_q <= IDX_W'(idx_q);
			res_steps_q <= steps_q;
		end
		if (cmd.out_load) begin
			result_value <= res_val_q;
			result_index <= res_idx_q;
			step_count <= res_steps_q;
		end
	end

endmodule

`default_nettype wire

>>> rtl/alt_checker.sv
// Port-level assertions for the arc length table, bound to the top level.
`default_nettype none

module alt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic [alt_pkg::MODE_W-1:0]  mode,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [alt_pkg::VAL_W-1:0]   result_value,
	input logic [alt_pkg::IDX_W-1:0]   result_index,
	input logic [alt_pkg::STEP_W-1:0]  step_count
);
	import alt_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_value)
			&& $stable(result_index) && $stable(step_count))
		else $error("result beat changed while stalled");

	a_step_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> step_count <= MAX_STEPS)
		else $error("bisection step count above limit");

	// a query occupies the block for at least the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (mode == MODE_FWD || mode == MODE_INV) |=> in_stall)
		else $error("query beat did not make the block busy");

	// loads never hold off the input
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode == MODE_LOAD |=> !in_stall)
		else $error("load beat stalled the input");

endmodule

bind arc_length_table_lookup alt_checker u_alt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.mode         (mode),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.result_value (result_value),
	.result_index (result_index),
	.step_count   (step_count)
);

`default_nettype wire

>>> tb/arc_length_table_lookup_tb.sv
// Self-checking testbench for the arc length table: loads, forward and inverse queries.
`default_nettype none

module arc_length_table_lookup_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import alt_pkg::*;

	localparam int MAX_INTERVALS = 1024;
	localparam int BISECT_FRAC = 52;
	localparam int SETTLE_CYCLES = 16;
	localparam int DRAIN_LIMIT = 200000;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic [CFG_IW-1:0] CFG_UNMAPPED_A = 2'd2;
	localparam logic [CFG_IW-1:0] CFG_UNMAPPED_B = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [IDX_W-1:0]  entry_index;
		logic [VAL_W-1:0]  entry_value;
		logic [VAL_W-1:0]  query_value;
	} lookup_beat_t;

	typedef struct packed {
		logic [VAL_W-1:0]  result_value;
		logic [IDX_W-1:0]  result_index;
		logic [STEP_W-1:0] step_count;
	} lookup_result_t;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_style_e;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [MODE_W-1:0] mode = '0;
	logic [IDX_W-1:0] entry_index = '0;
	logic [VAL_W-1:0] entry_value = '0;
	logic [VAL_W-1:0] query_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [VAL_W-1:0] result_value;
	logic [IDX_W-1:0] result_index;
	logic [STEP_W-1:0] step_count;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CFG_DW-1:0] cfg_data = '0;

	arc_length_table_lookup dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.entry_index(entry_index),
		.entry_value(entry_value),
		.query_value(query_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_value(result_value),
		.result_index(result_index),
		.step_count(step_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state: table copy and register copy
	logic [VAL_W-1:0] arc_mirror [0:MAX_INTERVALS];
	logic [IDX_W-1:0] cfg_count = COUNT_RST;
	logic [VAL_W-1:0] cfg_spacing = SPACING_RST;
	lookup_result_t expected_results[$];
	int fail_count = 0;

	// generator view of the table, so queries only touch loaded entries
	bit gen_written [0:MAX_INTERVALS];
	logic [VAL_W-1:0] gen_val [0:MAX_INTERVALS];
	int unsigned gen_cnt = 1;
	lookup_beat_t beat_queue[$];

	initial begin
		for (int i = 0; i <= MAX_INTERVALS; i++) begin
			arc_mirror[i] = '0;
			gen_written[i] = 1'b0;
			gen_val[i] = '0;
		end
	end

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned eff_count(input logic [IDX_W-1:0] c);
		if (c == 0)
			return 1;
		if (c > MAX_INTERVALS)
			return MAX_INTERVALS;
		return c;
	endfunction

	function automatic void predict_lookup(input lookup_beat_t b);
		lookup_result_t res;
		longint unsigned scaled, umin, umax, mid, prod;
		longint k, lo, hi, acc, qerr, step_gap, qv;
		int unsigned cnt, idx, pred, steps;
		cnt = eff_count(cfg_count);
		qv = b.query_value;
		case (b.mode)
		MODE_LOAD: begin
			if (b.entry_index <= MAX_INTERVALS)
				arc_mirror[b.entry_index] = b.entry_value;
		end
		MODE_FWD: begin
			scaled = qv * cnt;
			idx = scaled >> 16;
			if (idx > cnt - 1)
				idx = cnt - 1;
			k = scaled - longint'(idx) * 65536;
			lo = arc_mirror[idx];
			hi = arc_mirror[idx + 1];
			// arithmetic shift floors negative products
			acc = lo + ((k * (hi - lo) + 32768) >>> 16);
			if (acc < 0)
				res.result_value = '0;
			else if (acc > VAL_MAX)
				res.result_value = VAL_MAX;
			else
				res.result_value = acc[VAL_W-1:0];
			res.result_index = idx[IDX_W-1:0];
			res.step_count = '0;
			expected_results.insert(expected_results.size(), res);
		end
		MODE_INV: begin
			umin = 0;
			umax = 64'd1 << BISECT_FRAC;
			steps = 0;
			do begin
				mid = (umin + umax) >> 1;
				idx = (mid * cnt) >> BISECT_FRAC;
				if (idx > cnt - 1)
					idx = cnt - 1;
				pred = (idx == 0) ? 0 : idx - 1;
				lo = arc_mirror[idx];
				hi = arc_mirror[pred];
				step_gap = lo - hi;
				if (step_gap < 0)
					step_gap = -step_gap;
				qerr = lo - qv;
				if (qerr < 0)
					qerr = -qerr;
				if (lo > qv)
					umax = mid;
				else
					umin = mid;
				steps++;
			end while (!(qerr <= step_gap || steps >= MAX_STEPS));
			prod = longint'(idx) * cfg_spacing;
			res.result_value = (prod > VAL_MAX) ? VAL_MAX : prod[VAL_W-1:0];
			res.result_index = idx[IDX_W-1:0];
			res.step_count = steps[STEP_W-1:0];
			expected_results.insert(expected_results.size(), res);
		end
		default: ;
		endcase
	endfunction

	// sender: bursts of random length separated by random gaps
	lookup_beat_t drive_beat;
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall)
				predict_lookup(drive_beat);
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (beat_queue.size() != 0) begin
					drive_beat = beat_queue.pop_front();
					mode <= drive_beat.mode;
					entry_index <= drive_beat.entry_index;
					entry_value <= drive_beat.entry_value;
					query_value <= drive_beat.query_value;
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						if ($urandom_range(0, 3) == 0) begin
							gap_left = 0;
							burst_left = $urandom_range(50, 300);
						end else begin
							gap_left = $urandom_range(1, 20);
							burst_left = $urandom_range(1, 16);
						end
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern, switching style every so often
	stall_style_e stall_style = STALL_NONE;
	int stall_phase_left = 0;
	int stall_run_left = 0;
	logic stall_hold = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_phase_left = 0;
		end else begin
			if (stall_phase_left == 0) begin
				stall_style = stall_style_e'($urandom_range(0, 3));
				stall_phase_left = $urandom_range(16, 256);
			end else begin
				stall_phase_left--;
			end
			case (stall_style)
			STALL_NONE: out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default: begin
				if (stall_run_left == 0) begin
					stall_hold = ~stall_hold;
					stall_run_left = $urandom_range(1, 30);
				end else begin
					stall_run_left--;
				end
				out_stall <= stall_hold;
			end
			endcase
		end
	end

	lookup_result_t oldest_result;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: value %0d index %0d steps %0d",
					result_value, result_index, step_count);
				fail_count++;
			end else begin
				oldest_result = expected_results.pop_front();
				if (result_value !== oldest_result.result_value) begin
					$error("result_value: expected %0d, got %0d",
						oldest_result.result_value, result_value);
					fail_count++;
				end
				if (result_index !== oldest_result.result_index) begin
					$error("result_index: expected %0d, got %0d",
						oldest_result.result_index, result_index);
					fail_count++;
				end
				if (step_count !== oldest_result.step_count) begin
					$error("step_count: expected %0d, got %0d",
						oldest_result.step_count, step_count);
					fail_count++;
				end
			end
		end
	end

	function automatic logic [VAL_W-1:0] mono_value(input int unsigned slot);
		int v;
		v = int'(slot) * 65536 / int'(gen_cnt);
		return (v > VAL_MAX) ? VAL_MAX : v[VAL_W-1:0];
	endfunction

	function automatic void queue_load(input int unsigned slot, input logic [VAL_W-1:0] val);
		lookup_beat_t b;
		b.mode = MODE_LOAD;
		b.entry_index = slot[IDX_W-1:0];
		b.entry_value = val;
		b.query_value = VAL_W'($urandom);
		if (slot <= MAX_INTERVALS) begin
			gen_written[slot] = 1'b1;
			gen_val[slot] = val;
		end
		beat_queue.insert(beat_queue.size(), b);
	endfunction

	function automatic void queue_query(input logic [MODE_W-1:0] m, input logic [VAL_W-1:0] q);
		lookup_beat_t b;
		b.mode = m;
		b.entry_index = IDX_W'($urandom);
		b.entry_value = VAL_W'($urandom);
		b.query_value = q;
		beat_queue.insert(beat_queue.size(), b);
	endfunction

	// load entries 0..count; everything when asked, otherwise only the never-loaded ones
	function automatic void fill_table(input bit rewrite_all);
		for (int unsigned i = 0; i <= gen_cnt; i++)
			if (rewrite_all || !gen_written[i])
				queue_load(i, mono_value(i));
	endfunction

	task automatic wait_idle();
		while (beat_queue.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
		CFG_COUNT: cfg_count = data[IDX_W-1:0];
		CFG_SPACING: cfg_spacing = data;
		default: ;
		endcase
	endtask

	task automatic run_phase(input logic [IDX_W-1:0] count_w, input logic [VAL_W-1:0] spacing_w,
			input int n_items, input bit poke_unmapped);
		int counted, pick, sel, tmp;
		int unsigned slot;
		logic [VAL_W-1:0] val;
		wait_idle();
		write_reg(CFG_COUNT, count_w);
		write_reg(CFG_SPACING, spacing_w);
		if (poke_unmapped)
			write_reg($urandom_range(0, 1) ? CFG_UNMAPPED_A : CFG_UNMAPPED_B, CFG_DW'($urandom));
		gen_cnt = eff_count(count_w);
		fill_table(gen_cnt <= 64);
		counted = 0;
		while (counted < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				queue_load($urandom_range(MAX_INTERVALS + 1, 2047), VAL_W'($urandom));
			end else if (pick < 6) begin
				queue_query(MODE_UNUSED, VAL_W'($urandom));
			end else begin
				counted++;
				sel = $urandom_range(0, 19);
				if (pick < 18) begin
					slot = (sel < 3) ? $urandom_range(0, MAX_INTERVALS) : $urandom_range(0, gen_cnt);
					if (sel < 14)
						val = mono_value(slot) + VAL_W'($urandom_range(0, 7));
					else
						val = VAL_W'($urandom);
					queue_load(slot, val);
				end else if (pick < 58) begin
					if (sel < 12)
						tmp = $urandom_range(0, 65536);
					else if (sel < 15)
						tmp = int'(mono_value($urandom_range(0, gen_cnt))) + int'($urandom_range(0, 2)) - 1;
					else if (sel == 15)
						tmp = 0;
					else if (sel == 16)
						tmp = 65536;
					else
						tmp = $urandom_range(0, VAL_MAX);
					if (tmp < 0)
						tmp = 0;
					queue_query(MODE_FWD, tmp[VAL_W-1:0]);
				end else begin
					if (sel < 8)
						tmp = $urandom_range(0, 65536);
					else if (sel < 15)
						tmp = int'(gen_val[$urandom_range(0, gen_cnt)]) + int'($urandom_range(0, 6)) - 3;
					else if (sel == 15)
						tmp = 0;
					else if (sel == 16)
						tmp = 65536;
					else
						tmp = $urandom_range(0, VAL_MAX);
					if (tmp < 0)
						tmp = 0;
					if (tmp > VAL_MAX)
						tmp = VAL_MAX;
					queue_query(MODE_INV, tmp[VAL_W-1:0]);
				end
			end
		end
	endtask

	initial begin
		int unsigned rnd_cnt;
		int drained;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: 4 intervals over a linear table
		write_reg(CFG_COUNT, 11'd4);
		write_reg(CFG_SPACING, 17'd16384);
		gen_cnt = 4;
		fill_table(1'b1);
		queue_query(MODE_FWD, 17'd0);
		queue_query(MODE_FWD, 17'd1);
		queue_query(MODE_FWD, 17'd24576);
		queue_query(MODE_FWD, 17'd65535);
		queue_query(MODE_FWD, 17'd65536);
		queue_query(MODE_FWD, VAL_MAX);
		queue_query(MODE_INV, 17'd0);
		queue_query(MODE_INV, 17'd16384);
		queue_query(MODE_INV, 17'd30000);
		queue_query(MODE_INV, 17'd65536);
		queue_query(MODE_INV, VAL_MAX);
		queue_load(2047, VAL_MAX);
		queue_load(MAX_INTERVALS + 1, 17'd12345);
		queue_query(MODE_UNUSED, 17'd40000);
		// falling last interval: extrapolation past the end goes negative
		queue_load(4, 17'd0);
		queue_query(MODE_FWD, VAL_MAX);
		queue_load(2, VAL_MAX);
		queue_query(MODE_FWD, 17'd40000);
		queue_query(MODE_INV, 17'd70000);
		// flat table: bisection runs out of steps off the value, stops at once on it
		for (int unsigned i = 0; i <= 4; i++)
			queue_load(i, 17'd7777);
		queue_query(MODE_INV, 17'd60000);
		queue_query(MODE_INV, 17'd7777);

		// the full-size phase alone loads about a thousand entries
		run_phase(11'd4, 17'd16384, 60, 1'b0);
		run_phase(11'd1, 17'h10000, 50, 1'b1);
		run_phase(11'd0, VAL_MAX, 40, 1'b0);
		run_phase(11'd1024, 17'd64, 80, 1'b1);
		run_phase(11'd2047, 17'd0, 60, 1'b0);
		run_phase(11'd7, 17'd9362, 60, 1'b1);
		run_phase(11'd1000, VAL_MAX, 60, 1'b0);
		rnd_cnt = $urandom_range(2, 64);
		run_phase(rnd_cnt[IDX_W-1:0], VAL_W'(65536 / rnd_cnt), 60, 1'b1);
		run_phase(11'd300, 17'd218, 60, 1'b0);

		drained = 0;
		while ((beat_queue.size() != 0 || in_valid || expected_results.size() != 0)
				&& drained < DRAIN_LIMIT) begin
			@(posedge clk);
			drained++;
		end
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			fail_count++;
		end
		if (beat_queue.size() != 0 || in_valid) begin
			$error("input beats still pending at the end of the run");
			fail_count++;
		end
		repeat (120) @(posedge clk);
		if (fail_count == 0)
			$display("arc_length_table_lookup_tb OK");
		else
			$display("arc_length_table_lookup_tb NOT OK");
		$finish;
	end

	initial begin
		#16_000_000;
		$display("arc_length_table_lookup_tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
